// ===== hdl/pcvo_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcvo_pkg
// Shared constants and types for the point cloud voxel occupancy block.
// ----------------------------------------------------------------------------
package pcvo_pkg;

    localparam int GRID_SIZE = 64;
    localparam int HALF      = GRID_SIZE / 2;
    localparam int QUART     = GRID_SIZE / 4;
    localparam int ROWS      = GRID_SIZE * GRID_SIZE;
    localparam int CELLS     = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int XW        = $clog2(GRID_SIZE);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int CELL_W    = $clog2(CELLS);
    localparam int ADDR_W    = 18;
    localparam int ID_W      = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [ROW_W-1:0]  GRID_ROW  = ROW_W'(GRID_SIZE);
    localparam logic [CELL_W-1:0] GRID_CELL = CELL_W'(GRID_SIZE);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [31:0]       HALF_V    = 32'(HALF);
    localparam logic [XW-1:0]     GRID_OFS  = XW'(QUART + 1);
    localparam logic [31:0]       RECIP_RESET = 32'd65536;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTROID_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTROID_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTROID_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RECIP      = 3'd6;

    typedef struct packed {
        logic          ok;
        logic [XW-1:0] grid;
    } axis_t;

endpackage
`default_nettype wire

// ===== hdl/pcvo_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcvo_ram
// Simple dual-port RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module pcvo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/pcvo_axis.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcvo_axis
// Two-stage voxel index and centroid offset for one axis.
// ----------------------------------------------------------------------------
module pcvo_axis import pcvo_pkg::*; (
    input  wire logic        clk,
    input  wire logic        adv,
    input  wire logic [31:0] coord,
    input  wire logic [31:0] origin,
    input  wire logic [31:0] centroid,
    input  wire logic [31:0] recip,
    output axis_t            res,
    output logic      [31:0] rel
);

    logic [32:0] diff_reg;
    logic [32:0] diff_next;
    logic [32:0] rdiff;
    logic [31:0] rel1_reg;
    logic [31:0] rel1_next;
    logic [63:0] prod;
    logic [31:0] v_reg;
    logic        neg_reg;
    logic        rz_reg;
    logic [31:0] rel2_reg;

    always_comb
    begin
        diff_next = {coord[31], coord} - {origin[31], origin};
        rdiff     = {coord[31], coord} - {centroid[31], centroid};
        if (rdiff[32] != rdiff[31])
        begin
            rel1_next = rdiff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            rel1_next = rdiff[31:0];
        end
        prod = 64'(diff_reg[31:0]) * 64'(recip);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diff_reg <= diff_next;
            rel1_reg <= rel1_next;
            v_reg    <= prod[63:32];
            neg_reg  <= diff_reg[32];
            rz_reg   <= (recip == 32'd0);
            rel2_reg <= rel1_reg;
        end
    end

    always_comb
    begin
        if (rz_reg)
        begin
            res.ok   = 1'b1;
            res.grid = GRID_OFS;
        end
        else
        begin
            res.ok   = !neg_reg && (v_reg <= HALF_V);
            res.grid = v_reg[XW-1:0] + GRID_OFS;
        end
        rel = rel2_reg;
    end

endmodule
`default_nettype wire

// ===== hdl/point_cloud_voxel_occupancy.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// point_cloud_voxel_occupancy
// Voxelises a point stream and passes on the first point seen in each voxel.
//
// Channel  Handshake            Payload
// in       in_valid/in_ready    point_x, point_y, point_z
// out      out_valid/out_ready  voxel_address, point_id, rel_x, rel_y, rel_z
// cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One point per cycle unless stalled; a result passes the axis stages, the row
// lookup stage and the output register. The occupancy RAM holds one row of
// GRID_SIZE bits per (z, y); a point reads one row and, if passed on, writes
// it back, with the last written row forwarded. After reset a clearing pass
// zeroes all GRID_SIZE*GRID_SIZE rows (4096); in_ready stays low meanwhile.
// The pipeline stalls only when a result meets a full output register.
// ----------------------------------------------------------------------------
module point_cloud_voxel_occupancy import pcvo_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [31:0]          point_x,
    input  wire logic [31:0]          point_y,
    input  wire logic [31:0]          point_z,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [ADDR_W-1:0]    voxel_address,
    output logic      [ID_W-1:0]      point_id,
    output logic      [31:0]          rel_x,
    output logic      [31:0]          rel_y,
    output logic      [31:0]          rel_z,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    logic [31:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [31:0] cen_x_reg, cen_y_reg, cen_z_reg;
    logic [31:0] recip_reg;

    logic adv;
    logic accept;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;

    axis_t       ax, ay, az;
    logic [31:0] rx, ry, rz;

    logic [ROW_W-1:0]    row_next;
    logic [CELL_W-1:0]   cell_next;
    logic                s3_inwin_reg;
    logic [ROW_W-1:0]    s3_row_reg;
    logic [XW-1:0]       s3_x_reg;
    logic [ADDR_W-1:0]   s3_addr_reg;
    logic [31:0]         s3_rx_reg, s3_ry_reg, s3_rz_reg;

    logic [GRID_SIZE-1:0] rdata;
    logic [GRID_SIZE-1:0] row_cur;
    logic [GRID_SIZE-1:0] row_new;
    logic                 emit;

    logic                 fwd_valid_reg;
    logic [ROW_W-1:0]     fwd_row_reg;
    logic [GRID_SIZE-1:0] fwd_data_reg;

    logic                 clear_reg;
    logic [ROW_W-1:0]     clear_cnt_reg;

    logic                 ram_we;
    logic [ROW_W-1:0]     ram_waddr;
    logic [GRID_SIZE-1:0] ram_wdata;

    logic            out_valid_reg, out_valid_next;
    logic [ID_W-1:0] count_reg;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= 32'd0;
            origin_y_reg <= 32'd0;
            origin_z_reg <= 32'd0;
            cen_x_reg    <= 32'd0;
            cen_y_reg    <= 32'd0;
            cen_z_reg    <= 32'd0;
            recip_reg    <= RECIP_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X:   origin_x_reg <= cfg_data;
                REG_ORIGIN_Y:   origin_y_reg <= cfg_data;
                REG_ORIGIN_Z:   origin_z_reg <= cfg_data;
                REG_CENTROID_X: cen_x_reg    <= cfg_data;
                REG_CENTROID_Y: cen_y_reg    <= cfg_data;
                REG_CENTROID_Z: cen_z_reg    <= cfg_data;
                REG_RECIP:      recip_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    pcvo_axis u_axis_x (
        .clk(clk), .adv(adv), .coord(point_x), .origin(origin_x_reg),
        .centroid(cen_x_reg), .recip(recip_reg), .res(ax), .rel(rx)
    );
    pcvo_axis u_axis_y (
        .clk(clk), .adv(adv), .coord(point_y), .origin(origin_y_reg),
        .centroid(cen_y_reg), .recip(recip_reg), .res(ay), .rel(ry)
    );
    pcvo_axis u_axis_z (
        .clk(clk), .adv(adv), .coord(point_z), .origin(origin_z_reg),
        .centroid(cen_z_reg), .recip(recip_reg), .res(az), .rel(rz)
    );

    // row lookup, forwarding and mark
    always_comb
    begin
        row_next  = ROW_W'(az.grid) * GRID_ROW + ROW_W'(ay.grid);
        cell_next = CELL_W'(row_next) * GRID_CELL + CELL_W'(ax.grid);

        if (fwd_valid_reg && (fwd_row_reg == s3_row_reg))
        begin
            row_cur = fwd_data_reg;
        end
        else
        begin
            row_cur = rdata;
        end
        row_new = row_cur | ({{(GRID_SIZE-1){1'b0}}, 1'b1} << s3_x_reg);
        emit    = s3_valid_reg && s3_inwin_reg && !row_cur[s3_x_reg];

        adv      = !(emit && out_valid_reg && !out_ready);
        in_ready = adv && !clear_reg;
        accept   = in_valid && in_ready;

        if (clear_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clear_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = adv && emit;
            ram_waddr = s3_row_reg;
            ram_wdata = row_new;
        end
    end

    pcvo_ram #(
        .WIDTH(GRID_SIZE),
        .DEPTH(ROWS)
    ) u_occ_ram (
        .clk(clk),
        .we(ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re(adv),
        .raddr(row_next),
        .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clear_cnt_reg <= '0;
        end
        else if (clear_reg)
        begin
            clear_cnt_reg <= clear_cnt_reg + ROW_W'(1);
            if (clear_cnt_reg == ROW_LAST)
            begin
                clear_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            fwd_valid_reg <= emit;
            if (emit)
            begin
                count_reg <= count_reg + ID_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_inwin_reg <= ax.ok && ay.ok && az.ok;
            s3_row_reg   <= row_next;
            s3_x_reg     <= ax.grid;
            s3_addr_reg  <= ADDR_W'(cell_next);
            s3_rx_reg    <= rx;
            s3_ry_reg    <= ry;
            s3_rz_reg    <= rz;
            fwd_row_reg  <= s3_row_reg;
            fwd_data_reg <= row_new;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && emit)
        begin
            voxel_address <= s3_addr_reg;
            point_id      <= count_reg;
            rel_x         <= s3_rx_reg;
            rel_y         <= s3_ry_reg;
            rel_z         <= s3_rz_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire
